FILE: hw/rtl/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg: shared types and constants of the min-heap queue
// Request and status codes, store geometry and the sequencer's state type.
// ============================================================================
package bmhq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      REQ_INSERT  = 2'd0,
      REQ_PEEK    = 2'd1,
      REQ_EXTRACT = 2'd2,
      REQ_DELETE  = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP
   } state_type;

endpackage

FILE: hw/rtl/bmhq_ram.sv
// ============================================================================
// bmhq_ram: generic synchronous RAM
// One write port, two read ports, registered read data.
// ============================================================================
module bmhq_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [WIDTH-1:0]  rd_a_data,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

FILE: hw/rtl/binary_min_heap_queue_core.sv
// ============================================================================
// binary_min_heap_queue_core: min-heap priority queue of signed 32-bit keys
// Insert, peek, extract-min and delete-at-position over a heap held in RAM.
// ============================================================================
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+---------------------
//  request | req_type, req_key_in, req_position           | start & !busy
//  result  | rsp_key_out, rsp_status, rsp_entry_count     | rsp_valid, 1 cycle
//
//  Answers: a refused item answers in the next cycle; a peek answers from the
//  load state. Each sift level costs a RAM read state and a compare/write
//  state, so the heap depth (6 levels at 64 entries) sets the worst case.
//  Reset: synchronous, clears the fill count, the sequencer and rsp_valid only; the
//  store needs no clearing pass since only entries below the count are read.
//  Stalls: none on the result side; busy holds requests off while an item is in work.
//
module binary_min_heap_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic signed [31:0]          req_key_in,
   input  logic [5:0]                  req_position,
   output logic                        rsp_valid,
   output logic signed [31:0]          rsp_key_out,
   output logic [1:0]                  rsp_status,
   output logic [6:0]                  rsp_entry_count
);

   localparam int AW = bmhq_pkg::ADDR_W;
   localparam int CW = bmhq_pkg::CNT_W;
   localparam int KW = bmhq_pkg::KEY_W;

   // control state
   bmhq_pkg::state_type    state_ff, state_in;
   bmhq_pkg::req_type_type req_ff, req_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic                   first_ff, first_in;   // removal: up-or-down not yet decided

   // datapath: the moving key lives here, the RAM holds a hole at pos_ff
   logic [AW-1:0]          pos_ff, pos_in;
   logic signed [KW-1:0]   key_ff, key_in;
   logic signed [KW-1:0]   min_ff, min_in;

   // result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [KW-1:0]   rsp_key_ff, rsp_key_in;
   bmhq_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic signed [KW-1:0]   wr_data;
   logic [AW-1:0]          rd_a_addr, rd_b_addr;
   logic [KW-1:0]          rd_a_raw, rd_b_raw;
   logic signed [KW-1:0]   rd_a, rd_b;

   bmhq_ram #(
      .DEPTH (bmhq_pkg::CAPACITY),
      .WIDTH (KW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_raw),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_raw)
   );

   assign rd_a = $signed(rd_a_raw);
   assign rd_b = $signed(rd_b_raw);

   // ---- shared decisions ---------------------------------------------------
   logic [CW-1:0]  last_idx;          // count after a removal, index of last entry
   logic           is_full, is_empty, pos_bad, pos_is_last;
   logic [AW-1:0]  parent;
   logic [AW+1:0]  child_l, child_r;  // wide enough never to wrap
   logic           l_ok, r_ok, up_less, l_less, r_less;
   logic signed [KW-1:0] l_pick;

   assign last_idx    = fill_ff - CW'(1);
   assign is_full     = (fill_ff == CW'(bmhq_pkg::CAPACITY));
   assign is_empty    = (fill_ff == '0);
   assign pos_bad     = ({1'b0, req_position} >= fill_ff);
   assign pos_is_last = ({1'b0, pos_ff} == last_idx);
   assign parent      = AW'(pos_ff - AW'(1)) >> 1;
   assign child_l     = {1'b0, pos_ff, 1'b1};
   assign child_r     = child_l + (AW+2)'(1);
   assign l_ok        = (child_l < {1'b0, fill_ff});
   assign r_ok        = (child_r < {1'b0, fill_ff});
   assign up_less     = (key_ff < rd_a);
   assign l_less      = l_ok && (rd_a < key_ff);
   assign l_pick      = l_less ? rd_a : key_ff;
   assign r_less      = r_ok && (rd_b < l_pick);

   // ---- next state ----------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (start) begin
               unique case (req_type) inside
                  bmhq_pkg::REQ_INSERT:
                     state_in = is_full ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP_RD;
                  bmhq_pkg::REQ_PEEK, bmhq_pkg::REQ_EXTRACT:
                     state_in = is_empty ? bmhq_pkg::S_IDLE : bmhq_pkg::S_LOAD;
                  default:
                     state_in = (is_empty || pos_bad) ? bmhq_pkg::S_IDLE
                                                      : bmhq_pkg::S_LOAD;
               endcase
            end
         end
         bmhq_pkg::S_LOAD: begin
            if (req_ff == bmhq_pkg::REQ_PEEK || pos_is_last) begin
               state_in = bmhq_pkg::S_IDLE;
            end else begin
               state_in = bmhq_pkg::S_UP_RD;
            end
         end
         bmhq_pkg::S_UP_RD: begin
            if (pos_ff != '0) begin
               state_in = bmhq_pkg::S_UP_CMP;
            end else begin
               state_in = first_ff ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_IDLE;
            end
         end
         bmhq_pkg::S_UP_CMP: begin
            if (up_less) begin
               state_in = bmhq_pkg::S_UP_RD;
            end else begin
               state_in = first_ff ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_IDLE;
            end
         end
         bmhq_pkg::S_DN_RD: begin
            state_in = l_ok ? bmhq_pkg::S_DN_CMP : bmhq_pkg::S_IDLE;
         end
         bmhq_pkg::S_DN_CMP: begin
            state_in = (l_less || r_less) ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_IDLE;
         end
         default: state_in = bmhq_pkg::S_IDLE;
      endcase
   end

   // ---- datapath, RAM control and result ------------------------------------
   always_comb begin
      req_in        = req_ff;
      fill_in       = fill_ff;
      first_in      = first_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      min_in        = min_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = key_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = bmhq_pkg::ST_OK;

      unique case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (start) begin
               req_in   = bmhq_pkg::req_type_type'(req_type);
               first_in = 1'b0;
               unique case (req_type) inside
                  bmhq_pkg::REQ_INSERT: begin
                     if (is_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bmhq_pkg::ST_FULL;
                     end else begin
                        key_in  = req_key_in;
                        pos_in  = fill_ff[AW-1:0];
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  bmhq_pkg::REQ_PEEK, bmhq_pkg::REQ_EXTRACT: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bmhq_pkg::ST_EMPTY;
                     end else begin
                        rd_b_addr = last_idx[AW-1:0];
                        pos_in    = '0;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bmhq_pkg::ST_EMPTY;
                     end else if (pos_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bmhq_pkg::ST_BAD_POS;
                     end else begin
                        rd_b_addr = last_idx[AW-1:0];
                        pos_in    = req_position;
                     end
                  end
               endcase
            end
         end
         bmhq_pkg::S_LOAD: begin
            // port A: root, port B: last entry
            min_in = rd_a;
            key_in = rd_b;
            if (req_ff == bmhq_pkg::REQ_PEEK) begin
               rsp_valid_in = 1'b1;
            end else begin
               fill_in = last_idx;
               if (pos_is_last) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  first_in = 1'b1;
               end
            end
         end
         bmhq_pkg::S_UP_RD: begin
            if (pos_ff != '0) begin
               rd_a_addr = parent;
            end else if (!first_ff) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         bmhq_pkg::S_UP_CMP: begin
            if (up_less) begin
               wr_en    = 1'b1;
               wr_data  = rd_a;
               pos_in   = parent;
               first_in = 1'b0;
            end else if (!first_ff) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         bmhq_pkg::S_DN_RD: begin
            if (l_ok) begin
               rd_a_addr = child_l[AW-1:0];
               rd_b_addr = child_r[AW-1:0];
            end else begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         bmhq_pkg::S_DN_CMP: begin
            if (r_less) begin
               wr_en   = 1'b1;
               wr_data = rd_b;
               pos_in  = child_r[AW-1:0];
            end else if (l_less) begin
               wr_en   = 1'b1;
               wr_data = rd_a;
               pos_in  = child_l[AW-1:0];
            end else begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase

      // only a successful peek or extract reports a key
      rsp_key_in = (rsp_valid_in && rsp_status_in == bmhq_pkg::ST_OK &&
                    (req_in == bmhq_pkg::REQ_PEEK || req_in == bmhq_pkg::REQ_EXTRACT))
                   ? min_in : '0;
      rsp_count_in = fill_in;
   end

   // ---- registers -----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmhq_pkg::S_IDLE;
         fill_ff      <= '0;
         first_ff     <= 1'b0;
         req_ff       <= bmhq_pkg::REQ_INSERT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         first_ff     <= first_in;
         req_ff       <= req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      min_ff        <= min_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff != bmhq_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // ---- assertions ----------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(bmhq_pkg::CAPACITY))
      else $error("fill count beyond capacity");

   a_fill_step: assert property (@(posedge clock) disable iff (reset || $past(reset))
      !$stable(fill_ff) |-> (fill_ff == $past(fill_ff) + CW'(1) ||
                             fill_ff == $past(fill_ff) - CW'(1)))
      else $error("fill count moved by more than one");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != bmhq_pkg::S_IDLE && state_ff != bmhq_pkg::S_LOAD))
      else $error("store written outside a sift");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhq_pkg::ST_FULL) |->
         rsp_entry_count == CW'(bmhq_pkg::CAPACITY))
      else $error("full reported below capacity");

endmodule

FILE: tb/tb_binary_min_heap_queue_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_binary_min_heap_queue_core: self-checking bench for the min-heap queue
// Drives insert, peek, extract-min and delete-at-position items through the
// start/busy port and holds a shadow heap that predicts every result. Each
// result is compared field by field with the oldest prediction. The run
// starts with a directed part, fills the heap to capacity and then moves to
// random grow, shrink and mixed phases with bursty stimulus.
// ============================================================================
module tb_binary_min_heap_queue_core;

   localparam int RANDOM_ITEMS = 1000;
   localparam int TAIL_CYCLES  = 32;         // beyond the longest sift
   localparam int RUN_LIMIT_NS = 5_000_000;  // several times the slowest run

   // one predicted result
   typedef struct {
      logic signed [bmhq_pkg::KEY_W-1:0] key;
      bmhq_pkg::status_type              status;
      logic [bmhq_pkg::CNT_W-1:0]        count;
   } heap_answer_type;

   // -------------------------------------------------------------------------
   // Shadow heap: the same array layout as the block, so every removal moves
   // the last entry into the hole and the same positions hold the same keys.
   // -------------------------------------------------------------------------
   class heap_scoreboard;
      logic signed [bmhq_pkg::KEY_W-1:0] store [bmhq_pkg::CAPACITY];
      int                                fill;
      int                                peak_fill;
      int                                errors;
      int                                checked;
      int                                kind_seen [4];
      int                                status_seen [4];
      heap_answer_type                   awaited [$];

      function new();
         fill      = 0;
         peak_fill = 0;
         errors    = 0;
         checked   = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         foreach (store[i]) store[i] = '0;
      endfunction

      function void swap_at(int a, int b);
         logic signed [bmhq_pkg::KEY_W-1:0] t;
         t        = store[a];
         store[a] = store[b];
         store[b] = t;
      endfunction

      function void rise(int at);
         int up;
         while (at > 0 && at < fill) begin
            up = (at - 1) / 2;
            if (!(store[at] < store[up])) break;
            swap_at(at, up);
            at = up;
         end
      endfunction

      function void sink(int at);
         int best;
         int l;
         int r;
         while (at < fill) begin
            best = at;
            l    = 2 * at + 1;
            r    = 2 * at + 2;
            if (l < fill && store[l] < store[best]) best = l;
            if (r < fill && store[r] < store[best]) best = r;
            if (best == at) break;
            swap_at(at, best);
            at = best;
         end
      endfunction

      // last entry fills the hole, then goes up or down as its key requires
      function void take_out(int at);
         fill--;
         if (at < fill) begin
            store[at] = store[fill];
            if (at > 0 && store[at] < store[(at - 1) / 2]) rise(at);
            else sink(at);
         end
      endfunction

      function void note_request(bmhq_pkg::req_type_type kind,
                                 logic signed [bmhq_pkg::KEY_W-1:0] key,
                                 logic [bmhq_pkg::ADDR_W-1:0] pos);
         heap_answer_type ans;
         ans.key    = '0;
         ans.status = bmhq_pkg::ST_OK;
         kind_seen[kind]++;
         case (kind) inside
            bmhq_pkg::REQ_INSERT: begin
               if (fill >= bmhq_pkg::CAPACITY) begin
                  ans.status = bmhq_pkg::ST_FULL;
               end else begin
                  store[fill] = key;
                  fill++;
                  rise(fill - 1);
               end
            end
            bmhq_pkg::REQ_PEEK, bmhq_pkg::REQ_EXTRACT: begin
               if (fill == 0) begin
                  ans.status = bmhq_pkg::ST_EMPTY;
               end else begin
                  ans.key = store[0];
                  if (kind == bmhq_pkg::REQ_EXTRACT) take_out(0);
               end
            end
            default: begin
               if (fill == 0) ans.status = bmhq_pkg::ST_EMPTY;
               else if (int'(pos) >= fill) ans.status = bmhq_pkg::ST_BAD_POS;
               else take_out(int'(pos));
            end
         endcase
         ans.count = bmhq_pkg::CNT_W'(fill);
         status_seen[ans.status]++;
         if (fill > peak_fill) peak_fill = fill;
         awaited = {awaited, ans};
      endfunction

      function void check_result(logic signed [bmhq_pkg::KEY_W-1:0] key,
                                 logic [1:0] status,
                                 logic [bmhq_pkg::CNT_W-1:0] count);
         heap_answer_type ans;
         if (awaited.size() == 0) begin
            $error("result with no item outstanding: key_out %0d status %0d entry_count %0d",
                   key, status, count);
            errors++;
            return;
         end
         ans = awaited.pop_front();
         checked++;
         if (key !== ans.key) begin
            $error("key_out: expected %0d, got %0d", ans.key, key);
            errors++;
         end
         if (status !== ans.status) begin
            $error("status: expected %0d, got %0d", ans.status, status);
            errors++;
         end
         if (count !== ans.count) begin
            $error("entry_count: expected %0d, got %0d", ans.count, count);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, ports and the block
   // -------------------------------------------------------------------------
   logic                              clock        = 1'b0;
   logic                              reset        = 1'b1;
   logic                              start        = 1'b0;
   logic [1:0]                        req_type     = bmhq_pkg::REQ_PEEK;
   logic signed [bmhq_pkg::KEY_W-1:0] req_key_in   = '0;
   logic [bmhq_pkg::ADDR_W-1:0]       req_position = '0;
   logic                              busy;
   logic                              rsp_valid;
   logic signed [bmhq_pkg::KEY_W-1:0] rsp_key_out;
   logic [1:0]                        rsp_status;
   logic [bmhq_pkg::CNT_W-1:0]        rsp_entry_count;

   heap_scoreboard board;
   int             burst_left = 0;

   always #4 clock = ~clock;

   binary_min_heap_queue_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key_in      (req_key_in),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_key_out     (rsp_key_out),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // -------------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, before any of this
   // edge's updates land. The item is noted first so that a same-cycle answer
   // would still find its prediction waiting.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_request(bmhq_pkg::req_type_type'(req_type), req_key_in,
                               req_position);
         if (rsp_valid)
            board.check_result(rsp_key_out, rsp_status, rsp_entry_count);
      end
   end

   // -------------------------------------------------------------------------
   // Driving. start stays high from one item to the next within a burst, so it
   // only ever gets one assignment per edge.
   // -------------------------------------------------------------------------
   task automatic send_item(bmhq_pkg::req_type_type kind,
                            logic signed [bmhq_pkg::KEY_W-1:0] key,
                            logic [bmhq_pkg::ADDR_W-1:0] pos);
      start        <= 1'b1;
      req_type     <= kind;
      req_key_in   <= key;
      req_position <= pos;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold off until every outstanding item has answered
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // bursts of random length; a quarter of the bursts follow without a gap
   task automatic next_slot();
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 14));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // keys: extremes, a narrow band for duplicates, otherwise anything
   function automatic logic signed [bmhq_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000 + $urandom_range(0, 3);
         1:       return 32'h7fff_ffff - $urandom_range(0, 3);
         2, 3, 4: return int'($urandom_range(0, 40)) - 20;
         default: return $urandom;
      endcase
   endfunction

   // mostly positions that hold an entry, now and then any position
   function automatic logic [bmhq_pkg::ADDR_W-1:0] pick_position();
      if (board.fill > 0 && $urandom_range(0, 4) != 0)
         return bmhq_pkg::ADDR_W'($urandom_range(0, board.fill - 1));
      return bmhq_pkg::ADDR_W'($urandom_range(0, bmhq_pkg::CAPACITY - 1));
   endfunction

   // mode 0 grows the heap, 1 shrinks it, 2 is an even mix
   task automatic random_item(int mode);
      int                     roll;
      bmhq_pkg::req_type_type kind;
      roll = $urandom_range(0, 99);
      case (mode)
         0:       kind = roll < 75 ? bmhq_pkg::REQ_INSERT :
                         roll < 85 ? bmhq_pkg::REQ_PEEK :
                         roll < 95 ? bmhq_pkg::REQ_EXTRACT : bmhq_pkg::REQ_DELETE;
         1:       kind = roll < 15 ? bmhq_pkg::REQ_INSERT :
                         roll < 25 ? bmhq_pkg::REQ_PEEK :
                         roll < 65 ? bmhq_pkg::REQ_EXTRACT : bmhq_pkg::REQ_DELETE;
         default: kind = bmhq_pkg::req_type_type'(roll % 4);
      endcase
      next_slot();
      send_item(kind, pick_key(), pick_position());
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int sent;
      int mode;
      int phase_len;
      int errors;
      bit drained_midway;
      board          = new();
      sent           = 0;
      drained_midway = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty heap answers first
      send_item(bmhq_pkg::REQ_PEEK, 32'sd5, '0);
      send_item(bmhq_pkg::REQ_EXTRACT, 32'sd5, '0);
      send_item(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd0);
      send_item(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd63);
      // builds [0,100,1,101,102,2,3]
      send_item(bmhq_pkg::REQ_INSERT, 32'sd0, '0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd100, '0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd1, '0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd101, '0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd102, '0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd2, '0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd3, '0);
      // the moved-in last entry is below its new parent, so it must go up
      send_item(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd4);
      send_item(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd63);   // beyond the count
      send_item(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd6);    // exactly at the count
      send_item(bmhq_pkg::REQ_DELETE, 32'sd0, 6'd5);    // the last entry itself
      send_item(bmhq_pkg::REQ_INSERT, 32'h8000_0000, 6'h3f);
      send_item(bmhq_pkg::REQ_INSERT, 32'h7fff_ffff, '0);
      send_item(bmhq_pkg::REQ_INSERT, -32'sd1, '0);
      send_item(bmhq_pkg::REQ_PEEK, '0, '0);
      send_item(bmhq_pkg::REQ_EXTRACT, '0, '0);
      send_item(bmhq_pkg::REQ_DELETE, '0, 6'd0);        // root, sift down
      send_item(bmhq_pkg::REQ_DELETE, '0, 6'd2);
      send_item(bmhq_pkg::REQ_EXTRACT, '0, '0);
      send_item(bmhq_pkg::REQ_EXTRACT, '0, '0);
      drain();

      // fill to capacity, then knock on the full heap a few times
      while (board.fill < bmhq_pkg::CAPACITY) begin
         next_slot();
         send_item(bmhq_pkg::REQ_INSERT, pick_key(), pick_position());
         sent++;
      end
      repeat (4) begin
         next_slot();
         send_item(bmhq_pkg::REQ_INSERT, pick_key(), pick_position());
         sent++;
      end

      // phases of random length; shrink phases regularly empty the heap
      while (sent < RANDOM_ITEMS) begin
         mode      = $urandom_range(0, 2);
         phase_len = $urandom_range(10, 90);
         repeat (phase_len) begin
            random_item(mode);
            sent++;
         end
         if (!drained_midway && sent >= RANDOM_ITEMS / 2) begin
            drain();
            drained_midway = 1'b1;
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d items (%0d insert, %0d peek, %0d extract, %0d delete), %0d answers checked",
               board.kind_seen[bmhq_pkg::REQ_INSERT] + board.kind_seen[bmhq_pkg::REQ_PEEK] +
               board.kind_seen[bmhq_pkg::REQ_EXTRACT] + board.kind_seen[bmhq_pkg::REQ_DELETE],
               board.kind_seen[bmhq_pkg::REQ_INSERT], board.kind_seen[bmhq_pkg::REQ_PEEK],
               board.kind_seen[bmhq_pkg::REQ_EXTRACT], board.kind_seen[bmhq_pkg::REQ_DELETE],
               board.checked);
      $display("Status codes: ok %0d, empty %0d, full %0d, bad position %0d; peak fill %0d",
               board.status_seen[bmhq_pkg::ST_OK], board.status_seen[bmhq_pkg::ST_EMPTY],
               board.status_seen[bmhq_pkg::ST_FULL], board.status_seen[bmhq_pkg::ST_BAD_POS],
               board.peak_fill);

      errors = board.errors + board.pending();
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ram.sv
hw/rtl/binary_min_heap_queue_core.sv
tb/tb_binary_min_heap_queue_core.sv
